@@ rtl/core/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg
// Types, constants and floating-point helpers shared by the column projection
// residual block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_TESTS = 16;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int TEST_W    = $clog2(MAX_TESTS);
  localparam int ADDR_W    = ROW_W + TEST_W;
  localparam int CNT_W     = 20;
  localparam int RC_W      = 11;
  localparam int TC_W      = 5;
  localparam int TRAIN_W   = 21;
  localparam int REG_W     = 2;
  localparam int KIND_W    = 2;

  localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FP_QUIET_BIT   = 64'h0008_0000_0000_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_ACOL = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [REG_W-1:0] {
    REG_ROW_COUNT   = 2'd0,
    REG_TEST_COUNT  = 2'd1,
    REG_TRAIN_COUNT = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_index_e;

  typedef enum logic [1:0] {
    FOP_MUL = 2'd0,
    FOP_ADD = 2'd1,
    FOP_SUB = 2'd2,
    FOP_NOP = 2'd3
  } fpu_op_e;

  typedef enum logic [1:0] {
    SEL_DOT_MUL = 2'd0,
    SEL_DOT_ADD = 2'd1,
    SEL_UPD_MUL = 2'd2,
    SEL_UPD_SUB = 2'd3
  } fpu_sel_e;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_MUL,
    FS_ALIGN,
    FS_ADD,
    FS_NEG,
    FS_NORM,
    FS_ROUND,
    FS_PACK,
    FS_DONE
  } fpu_state_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_READ_EMIT,
    CS_DOT_READ,
    CS_DOT_MUL,
    CS_DOT_MUL_WAIT,
    CS_DOT_ADD,
    CS_DOT_ADD_WAIT,
    CS_DOT_EMIT,
    CS_UPD_READ,
    CS_UPD_MUL,
    CS_UPD_MUL_WAIT,
    CS_UPD_SUB,
    CS_UPD_SUB_WAIT
  } ctrl_state_e;

  typedef struct packed {
    kind_e              kind;
    logic [ROW_W-1:0]   row;
    logic [TEST_W-1:0]  col;
    logic [63:0]        b_value;
    logic [63:0]        residual_value;
    logic [63:0]        a_value;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [CNT_W-1:0]   train_index;
    logic [TEST_W-1:0]  test_index;
    logic [63:0]        value;
    logic               last;
    logic               final_res;
  } out_item_t;

  typedef struct packed {
    logic                en;
    reg_index_e          index;
    logic [TRAIN_W-1:0]  data;
  } cfg_write_t;

  typedef struct packed {
    logic      accept;
    logic      rd_issue;
    logic      fpu_start;
    fpu_sel_e  fpu_sel;
    logic      p_load;
    logic      acc_load;
    logic      acc_clear;
    logic      m_clear;
    logic      m_inc;
    logic      t_clear;
    logic      t_inc;
    logic      r_write;
    logic      out_load_dot;
    logic      out_load_read;
    logic      cnt_advance;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e  in_kind;
    logic   a_end;
    logic   m_last;
    logic   t_last;
    logic   fpu_done;
    logic   out_free;
  } dp_status_t;

  function automatic logic [52:0] fp_mant(input logic [63:0] x);
    return {|x[62:52], x[51:0]};
  endfunction

  function automatic logic signed [13:0] fp_exp(input logic [63:0] x);
    logic [10:0] ex;
    ex = x[62:52];
    if (ex == 11'd0) begin
      ex = 11'd1;
    end
    return $signed({3'b000, ex}) - 14'sd1075;
  endfunction

  function automatic logic fp_is_nan(input logic [63:0] x);
    return (&x[62:52]) & (|x[51:0]);
  endfunction

  function automatic logic fp_is_inf(input logic [63:0] x);
    return (&x[62:52]) & ~(|x[51:0]);
  endfunction

  function automatic logic fp_is_zero(input logic [63:0] x);
    return ~(|x[62:0]);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cpr_if.sv @@
// ----------------------------------------------------------------------------
// cpr_if
// Channel interfaces of the column projection residual block: input items,
// result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cpr_in_if
  import cpr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ROW_W-1:0]    row;
  logic [TEST_W-1:0]   col;
  logic [63:0]         b_value;
  logic [63:0]         residual_value;
  logic [63:0]         a_value;

  modport source (output valid, kind, row, col, b_value, residual_value, a_value,
                  input ready);
  modport sink (input valid, kind, row, col, b_value, residual_value, a_value,
                output ready);
endinterface

interface cpr_out_if
  import cpr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [CNT_W-1:0]   train_index;
  logic [TEST_W-1:0]  test_index;
  logic [63:0]        value;
  logic               last;
  logic               final_res;

  modport source (output valid, result_kind, train_index, test_index, value, last,
                  final_res, input ready);
  modport sink (input valid, result_kind, train_index, test_index, value, last,
                final_res, output ready);
endinterface

interface cpr_cfg_if
  import cpr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [REG_W-1:0]    index;
  logic [TRAIN_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cpr_ram.sv @@
// ----------------------------------------------------------------------------
// cpr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/cpr_fpu.sv @@
// ----------------------------------------------------------------------------
// cpr_fpu
// Multi-cycle IEEE double multiplier and adder with round to nearest even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_fpu
  import cpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  fpu_op_e     op_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  fpu_state_e           state_q, state_d;
  logic [63:0]          a_q, a_d, b_q, b_d, res_q, res_d;
  logic [127:0]         x_q, x_d, y_q, y_d, m_q, m_d;
  logic signed [13:0]   e_q, e_d;
  logic                 s_q, s_d, sy_q, sy_d, sub_q, sub_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [53:0]          q_q, q_d;
  logic [12:0]          em1_q, em1_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
    e_q   <= e_d;
    s_q   <= s_d;
    sy_q  <= sy_d;
    sub_q <= sub_d;
    cnt_q <= cnt_d;
    q_q   <= q_d;
    em1_q <= em1_d;
  end

  always_comb begin
    logic [52:0]        ma, mb;
    logic signed [13:0] ea, eb, dd, sh;
    logic [127:0]       lesser, mask;
    logic [128:0]       diff;
    logic [26:0]        pa, pb;
    logic [53:0]        pp;
    logic [127:0]       ppw;
    logic [6:0]         sh7, rpos;
    logic [7:0]         sh8;
    logic [52:0]        qs;
    logic               rbit, st, up, sbe;
    logic [64:0]        wide;

    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    res_d   = res_q;
    x_d     = x_q;
    y_d     = y_q;
    m_d     = m_q;
    e_d     = e_q;
    s_d     = s_q;
    sy_d    = sy_q;
    sub_d   = sub_q;
    cnt_d   = cnt_q;
    q_d     = q_q;
    em1_d   = em1_q;

    ma     = fp_mant(a_q);
    mb     = fp_mant(b_q);
    ea     = fp_exp(a_q);
    eb     = fp_exp(b_q);
    dd     = 14'sd0;
    sh     = 14'sd0;
    lesser = '0;
    mask   = '0;
    diff   = '0;
    pa     = '0;
    pb     = '0;
    pp     = '0;
    ppw    = '0;
    sh7    = '0;
    rpos   = '0;
    sh8    = '0;
    qs     = '0;
    rbit   = 1'b0;
    st     = 1'b0;
    up     = 1'b0;
    sbe    = 1'b0;
    wide   = '0;

    unique case (state_q)
      FS_IDLE: begin
        if (start_i) begin
          a_d   = a_i;
          b_d   = b_i;
          sub_d = (op_i == FOP_SUB);
          sbe   = b_i[63] ^ (op_i == FOP_SUB);
          state_d = FS_DONE;
          if (fp_is_nan(a_i)) begin
            res_d = a_i | FP_QUIET_BIT;
          end else if (fp_is_nan(b_i)) begin
            res_d = b_i | FP_QUIET_BIT;
          end else if (op_i == FOP_MUL) begin
            if ((fp_is_inf(a_i) && fp_is_zero(b_i)) || (fp_is_zero(a_i) && fp_is_inf(b_i)))
            begin
              res_d = FP_DEFAULT_NAN;
            end else if (fp_is_inf(a_i) || fp_is_inf(b_i)) begin
              res_d = {a_i[63] ^ b_i[63], 11'h7FF, 52'd0};
            end else begin
              m_d     = '0;
              cnt_d   = 2'd0;
              e_d     = fp_exp(a_i) + fp_exp(b_i);
              s_d     = a_i[63] ^ b_i[63];
              state_d = FS_MUL;
            end
          end else begin
            if (fp_is_inf(a_i) && fp_is_inf(b_i) && (a_i[63] != sbe)) begin
              res_d = FP_DEFAULT_NAN;
            end else if (fp_is_inf(a_i)) begin
              res_d = a_i;
            end else if (fp_is_inf(b_i)) begin
              res_d = {sbe, b_i[62:0]};
            end else begin
              state_d = FS_ALIGN;
            end
          end
        end
      end

      FS_MUL: begin
        unique case (cnt_q)
          2'd0: begin
            pa  = {1'b0, ma[25:0]};
            pb  = {1'b0, mb[25:0]};
            pp  = pa * pb;
            ppw = {74'd0, pp};
          end
          2'd1: begin
            pa  = {1'b0, ma[25:0]};
            pb  = mb[52:26];
            pp  = pa * pb;
            ppw = {74'd0, pp} << 26;
          end
          2'd2: begin
            pa  = ma[52:26];
            pb  = {1'b0, mb[25:0]};
            pp  = pa * pb;
            ppw = {74'd0, pp} << 26;
          end
          default: begin
            pa  = ma[52:26];
            pb  = mb[52:26];
            pp  = pa * pb;
            ppw = {74'd0, pp} << 52;
          end
        endcase
        m_d   = m_q + ppw;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = FS_NORM;
        end
      end

      FS_ALIGN: begin
        sbe = b_q[63] ^ sub_q;
        if (ea >= eb) begin
          dd     = ea - eb;
          x_d    = {11'd0, ma, 64'd0};
          lesser = {11'd0, mb, 64'd0};
          e_d    = ea - 14'sd64;
          s_d    = a_q[63];
          sy_d   = sbe;
        end else begin
          dd     = eb - ea;
          x_d    = {11'd0, mb, 64'd0};
          lesser = {11'd0, ma, 64'd0};
          e_d    = eb - 14'sd64;
          s_d    = sbe;
          sy_d   = a_q[63];
        end
        if (dd > 14'sd127) begin
          y_d = {127'd0, |lesser};
        end else begin
          sh7  = dd[6:0];
          mask = (128'd1 << sh7) - 128'd1;
          y_d  = (lesser >> sh7) | {127'd0, |(lesser & mask)};
        end
        state_d = FS_ADD;
      end

      FS_ADD: begin
        if (s_q == sy_q) begin
          m_d     = x_q + y_q;
          state_d = FS_NORM;
        end else begin
          diff = {1'b0, x_q} - {1'b0, y_q};
          m_d  = diff[127:0];
          if (diff[128]) begin
            s_d     = sy_q;
            state_d = FS_NEG;
          end else begin
            if (diff == '0) begin
              s_d = 1'b0;
            end
            state_d = FS_NORM;
          end
        end
      end

      FS_NEG: begin
        m_d     = ~m_q + 128'd1;
        state_d = FS_NORM;
      end

      FS_NORM: begin
        priority if (m_q == '0) begin
          res_d   = {s_q, 63'd0};
          state_d = FS_DONE;
        end else if (m_q[127:112] == 16'd0) begin
          m_d = m_q << 16;
          e_d = e_q - 14'sd16;
        end else if (!m_q[127]) begin
          m_d = m_q << 1;
          e_d = e_q - 14'sd1;
        end else begin
          state_d = FS_ROUND;
        end
      end

      FS_ROUND: begin
        sh = -14'sd1074 - e_q;
        if (sh <= 14'sd75) begin
          sh8   = 8'd75;
          em1_d = 13'(e_q + 14'sd1149);
        end else begin
          em1_d = 13'd0;
          sh8   = (sh >= 14'sd129) ? 8'd129 : sh[7:0];
        end
        if (sh8 == 8'd129) begin
          qs   = '0;
          rbit = 1'b0;
          st   = 1'b1;
        end else begin
          qs   = 53'(m_q >> sh8);
          rpos = 7'(sh8 - 8'd1);
          rbit = m_q[rpos];
          mask = (128'd1 << rpos) - 128'd1;
          st   = |(m_q & mask);
        end
        up      = rbit & (st | qs[0]);
        q_d     = {1'b0, qs} + {53'd0, up};
        state_d = FS_PACK;
      end

      FS_PACK: begin
        wide = {em1_q, 52'd0} + {11'd0, q_q};
        if (wide[64:52] >= 13'd2047) begin
          res_d = {s_q, 11'h7FF, 52'd0};
        end else begin
          res_d = {s_q, wide[62:0]};
        end
        state_d = FS_DONE;
      end

      FS_DONE: begin
        state_d = FS_IDLE;
      end

      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  assign done_o   = (state_q == FS_DONE);
  assign result_o = res_q;

endmodule

`default_nettype wire

@@ rtl/core/cpr_datapath.sv @@
// ----------------------------------------------------------------------------
// cpr_datapath
// Stores, configuration, counters, floating-point unit and output register
// of the column projection residual block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_datapath
  import cpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_write_t  cfg_i,
  input  in_item_t    item_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output out_item_t   out_item_o
);

  logic [RC_W-1:0]    row_count_q;
  logic [TC_W-1:0]    test_count_q;
  logic [TRAIN_W-1:0] train_count_q;
  logic [ROW_W-1:0]   rows_m1;
  logic [TEST_W-1:0]  tests_m1;
  logic [TRAIN_W-1:0] train_m1;

  logic [ROW_W-1:0]   m_q;
  logic [TEST_W-1:0]  t_q, rd_col_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [63:0]        acc_q, p_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               is_final, m_last, t_last, out_free;
  logic [63:0]        a_rd, b_rd, r_rd;
  logic               r_we, r_re;
  logic [ADDR_W-1:0]  r_waddr, r_raddr, tm_addr, in_addr;
  logic [63:0]        r_wdata;
  fpu_op_e            fpu_op;
  logic [63:0]        fpu_a, fpu_b, fpu_res;
  logic               fpu_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q   <= RC_W'(MAX_ROWS);
      test_count_q  <= TC_W'(MAX_TESTS);
      train_count_q <= TRAIN_W'(1);
    end else if (cfg_i.en) begin
      unique case (cfg_i.index)
        REG_ROW_COUNT:   row_count_q   <= cfg_i.data[RC_W-1:0];
        REG_TEST_COUNT:  test_count_q  <= cfg_i.data[TC_W-1:0];
        REG_TRAIN_COUNT: train_count_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (row_count_q == '0) begin
      rows_m1 = '0;
    end else if (row_count_q > RC_W'(MAX_ROWS)) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(row_count_q - RC_W'(1));
    end
    priority if (test_count_q == '0) begin
      tests_m1 = '0;
    end else if (test_count_q > TC_W'(MAX_TESTS)) begin
      tests_m1 = TEST_W'(MAX_TESTS - 1);
    end else begin
      tests_m1 = TEST_W'(test_count_q - TC_W'(1));
    end
    train_m1 = (train_count_q == '0) ? '0 : train_count_q - TRAIN_W'(1);
  end

  assign is_final = ({1'b0, cnt_q} == train_m1);
  assign m_last   = (m_q == rows_m1);
  assign t_last   = (t_q == tests_m1);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q         <= '0;
      t_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.m_clear) begin
        m_q <= '0;
      end else if (cmd_i.m_inc) begin
        m_q <= m_q + ROW_W'(1);
      end
      if (cmd_i.t_clear) begin
        t_q <= '0;
      end else if (cmd_i.t_inc) begin
        t_q <= t_q + TEST_W'(1);
      end
      if (cmd_i.cnt_advance) begin
        cnt_q <= is_final ? '0 : cnt_q + CNT_W'(1);
      end
      if (cmd_i.out_load_dot || cmd_i.out_load_read) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_col_q <= item_i.col;
    end
    if (cmd_i.acc_clear) begin
      acc_q <= '0;
    end else if (cmd_i.acc_load) begin
      acc_q <= fpu_res;
    end
    if (cmd_i.p_load) begin
      p_q <= fpu_res;
    end
    if (cmd_i.out_load_dot) begin
      out_q <= '{result_kind: 1'b0, train_index: cnt_q, test_index: t_q, value: acc_q,
                 last: t_last, final_res: t_last && is_final};
    end else if (cmd_i.out_load_read) begin
      out_q <= '{result_kind: 1'b1, train_index: '0, test_index: rd_col_q, value: r_rd,
                 last: 1'b0, final_res: 1'b0};
    end
  end

  assign tm_addr = {t_q, m_q};
  assign in_addr = {item_i.col, item_i.row};

  cpr_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && (item_i.kind == KIND_ACOL)),
    .waddr_i (item_i.row),
    .wdata_i (item_i.a_value),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (m_q),
    .rdata_o (a_rd)
  );

  cpr_ram #(.WIDTH(64), .DEPTH(MAX_ROWS * MAX_TESTS)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && (item_i.kind == KIND_LOAD)),
    .waddr_i (in_addr),
    .wdata_i (item_i.b_value),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (tm_addr),
    .rdata_o (b_rd)
  );

  assign r_we    = cmd_i.r_write || (cmd_i.accept && (item_i.kind == KIND_LOAD));
  assign r_waddr = cmd_i.r_write ? tm_addr : in_addr;
  assign r_wdata = cmd_i.r_write ? fpu_res : item_i.residual_value;
  assign r_re    = cmd_i.rd_issue || (cmd_i.accept && (item_i.kind == KIND_READ));
  assign r_raddr = cmd_i.rd_issue ? tm_addr : in_addr;

  cpr_ram #(.WIDTH(64), .DEPTH(MAX_ROWS * MAX_TESTS)) u_r_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (r_re),
    .raddr_i (r_raddr),
    .rdata_o (r_rd)
  );

  always_comb begin
    unique case (cmd_i.fpu_sel)
      SEL_DOT_MUL: begin
        fpu_op = FOP_MUL;
        fpu_a  = a_rd;
        fpu_b  = b_rd;
      end
      SEL_DOT_ADD: begin
        fpu_op = FOP_ADD;
        fpu_a  = acc_q;
        fpu_b  = p_q;
      end
      SEL_UPD_MUL: begin
        fpu_op = FOP_MUL;
        fpu_a  = a_rd;
        fpu_b  = acc_q;
      end
      default: begin
        fpu_op = FOP_SUB;
        fpu_a  = r_rd;
        fpu_b  = p_q;
      end
    endcase
  end

  cpr_fpu u_fpu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.fpu_start),
    .op_i     (fpu_op),
    .a_i      (fpu_a),
    .b_i      (fpu_b),
    .done_o   (fpu_done),
    .result_o (fpu_res)
  );

  assign sts_o = '{in_kind: item_i.kind, a_end: (item_i.row == rows_m1), m_last: m_last,
                   t_last: t_last, fpu_done: fpu_done, out_free: out_free};

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/cpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer of the column projection residual block: input transfers, reads,
// dot products and residual updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_ctrl
  import cpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dp_status_t  sts_i,
  output ctrl_cmd_t   cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.in_kind)
            KIND_READ: begin
              state_d = CS_READ_EMIT;
            end
            KIND_ACOL: begin
              if (sts_i.a_end) begin
                cmd_o.acc_clear = 1'b1;
                cmd_o.m_clear   = 1'b1;
                cmd_o.t_clear   = 1'b1;
                state_d         = CS_DOT_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      CS_READ_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load_read = 1'b1;
          state_d             = CS_IDLE;
        end
      end

      CS_DOT_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = CS_DOT_MUL;
      end

      CS_DOT_MUL: begin
        cmd_o.fpu_start = 1'b1;
        cmd_o.fpu_sel   = SEL_DOT_MUL;
        state_d         = CS_DOT_MUL_WAIT;
      end

      CS_DOT_MUL_WAIT: begin
        if (sts_i.fpu_done) begin
          cmd_o.p_load = 1'b1;
          state_d      = CS_DOT_ADD;
        end
      end

      CS_DOT_ADD: begin
        cmd_o.fpu_start = 1'b1;
        cmd_o.fpu_sel   = SEL_DOT_ADD;
        state_d         = CS_DOT_ADD_WAIT;
      end

      CS_DOT_ADD_WAIT: begin
        if (sts_i.fpu_done) begin
          cmd_o.acc_load = 1'b1;
          if (sts_i.m_last) begin
            state_d = CS_DOT_EMIT;
          end else begin
            cmd_o.m_inc = 1'b1;
            state_d     = CS_DOT_READ;
          end
        end
      end

      CS_DOT_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load_dot = 1'b1;
          cmd_o.m_clear      = 1'b1;
          state_d            = CS_UPD_READ;
        end
      end

      CS_UPD_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = CS_UPD_MUL;
      end

      CS_UPD_MUL: begin
        cmd_o.fpu_start = 1'b1;
        cmd_o.fpu_sel   = SEL_UPD_MUL;
        state_d         = CS_UPD_MUL_WAIT;
      end

      CS_UPD_MUL_WAIT: begin
        if (sts_i.fpu_done) begin
          cmd_o.p_load = 1'b1;
          state_d      = CS_UPD_SUB;
        end
      end

      CS_UPD_SUB: begin
        cmd_o.fpu_start = 1'b1;
        cmd_o.fpu_sel   = SEL_UPD_SUB;
        state_d         = CS_UPD_SUB_WAIT;
      end

      CS_UPD_SUB_WAIT: begin
        if (sts_i.fpu_done) begin
          cmd_o.r_write = 1'b1;
          if (!sts_i.m_last) begin
            cmd_o.m_inc = 1'b1;
            state_d     = CS_UPD_READ;
          end else if (sts_i.t_last) begin
            cmd_o.cnt_advance = 1'b1;
            state_d           = CS_IDLE;
          end else begin
            cmd_o.t_inc     = 1'b1;
            cmd_o.m_clear   = 1'b1;
            cmd_o.acc_clear = 1'b1;
            state_d         = CS_DOT_READ;
          end
        end
      end

      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/column_projection_residual.sv @@
// ----------------------------------------------------------------------------
// column_projection_residual
// Streams columns of A against stored matrices B and R: emits each dot
// product with a column of B and subtracts the rank-one update from R.
//
// Usage: configure row_count, test_count and train_count on cfg_i while idle.
// Items of kind load write one element of B and R; kind read returns one R
// entry on out_o through the output register. Items of kind A column are
// buffered; the element at row row_count-1 starts the column work, which
// for each test column runs a dot product over row_count rows, emits it, and
// then updates row_count entries of R. Each step uses one shared
// floating-point unit. Loads and non-final A elements are taken without
// leaving the idle state. No input is taken while a read or a column is in
// progress. Results wait in an output register; when the receiver stalls,
// the block holds there until the register frees. Reset clears the control
// state, the counters and the output valid flag and sets the configuration
// registers to their defaults; the stores are not cleared and must be
// written before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module column_projection_residual
  import cpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cpr_cfg_if.sink     cfg_i,
  cpr_in_if.sink      in_i,
  cpr_out_if.source   out_o
);

  cfg_write_t  cfg_wr;
  in_item_t    item;
  ctrl_cmd_t   cmd;
  dp_status_t  sts;
  out_item_t   out_item;
  logic        out_valid;
  logic        in_ready;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr = '{en: cfg_i.valid, index: reg_index_e'(cfg_i.index), data: cfg_i.data};

  assign item = '{kind: kind_e'(in_i.kind), row: in_i.row, col: in_i.col,
                  b_value: in_i.b_value, residual_value: in_i.residual_value,
                  a_value: in_i.a_value};

  assign in_i.ready = in_ready;

  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign out_o.valid       = out_valid;
  assign out_o.result_kind = out_item.result_kind;
  assign out_o.train_index = out_item.train_index;
  assign out_o.test_index  = out_item.test_index;
  assign out_o.value       = out_item.value;
  assign out_o.last        = out_item.last;
  assign out_o.final_res   = out_item.final_res;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for column_projection_residual: loads B and R, streams
// A columns, reads back residuals, and checks every result transfer against
// a double-precision predictor of the dot products and rank-one updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cpr_pkg::*;

  typedef struct {
    in_item_t    it;
    bit          typed;
    logic [63:0] expv;
  } dir_row_t;

  logic clk;
  logic rst_n;

  cpr_in_if  in_if ();
  cpr_out_if out_if ();
  cpr_cfg_if cfg_if ();

  column_projection_residual DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [63:0]        b_mem   [MAX_TESTS*MAX_ROWS];
  logic [63:0]        r_mem   [MAX_TESTS*MAX_ROWS];
  logic [63:0]        a_buf   [MAX_ROWS];
  logic [CNT_W-1:0]   col_no;
  logic [RC_W-1:0]    rows_reg;
  logic [TC_W-1:0]    tests_reg;
  logic [TRAIN_W-1:0] train_reg;

  out_item_t exp_q[$];
  int errors;
  int sent;
  int dots_seen;
  int reads_seen;
  int mode;
  logic long_hold;
  bit hold_req;

  always #5 clk = ~clk;

  function automatic int eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int eff_tests();
    if (tests_reg == 0) return 1;
    if (tests_reg > MAX_TESTS) return MAX_TESTS;
    return tests_reg;
  endfunction

  function automatic void predict_results(in_item_t it);
    int idx;
    int n;
    int nt;
    logic [TRAIN_W-1:0] tc;
    bit fin;
    real acc;
    out_item_t o;
    idx = it.col * MAX_ROWS + it.row;
    case (it.kind)
      KIND_LOAD: begin
        b_mem[idx] = it.b_value;
        r_mem[idx] = it.residual_value;
      end
      KIND_READ: begin
        o = '{1'b1, '0, it.col, r_mem[idx], 1'b0, 1'b0};
        exp_q.push_back(o);
      end
      KIND_ACOL: begin
        a_buf[it.row] = it.a_value;
        n = eff_rows();
        nt = eff_tests();
        tc = (train_reg == 0) ? 1 : train_reg;
        fin = ({1'b0, col_no} == tc - 1);
        if (it.row == n - 1) begin
          for (int t = 0; t < nt; t++) begin
            acc = 0.0;
            for (int m = 0; m < n; m++)
              acc = acc + $bitstoreal(a_buf[m]) * $bitstoreal(b_mem[t*MAX_ROWS+m]);
            for (int m = 0; m < n; m++)
              r_mem[t*MAX_ROWS+m] = $realtobits($bitstoreal(r_mem[t*MAX_ROWS+m])
                                    - $bitstoreal(a_buf[m]) * acc);
            o = '{1'b0, col_no, t[TEST_W-1:0], $realtobits(acc), t == nt - 1,
                  (t == nt - 1) && fin};
            exp_q.push_back(o);
          end
          col_no = fin ? '0 : col_no + 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    v[62:52] = 11'(1019 + $urandom_range(0, 8));
    if ($urandom_range(0, 19) == 0) v[62:0] = '0;
    return v;
  endfunction

  function automatic in_item_t make_item(kind_e k, int row, int col);
    in_item_t it;
    it.kind = k;
    it.row = row[ROW_W-1:0];
    it.col = col[TEST_W-1:0];
    it.b_value = rand_double();
    it.residual_value = rand_double();
    it.a_value = rand_double();
    return it;
  endfunction

  task automatic send(in_item_t it);
    int pct;
    pct = (mode == 0) ? 25 : (mode == 1) ? 51 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= it.kind;
    in_if.row <= it.row;
    in_if.col <= it.col;
    in_if.b_value <= it.b_value;
    in_if.residual_value <= it.residual_value;
    in_if.a_value <= it.a_value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_results(it);
    sent++;
    mode = (sent < 90) ? 0 : (sent < 180) ? 1 : 2;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_e idx, logic [TRAIN_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_ROW_COUNT:   rows_reg = data[RC_W-1:0];
      REG_TEST_COUNT:  tests_reg = data[TC_W-1:0];
      REG_TRAIN_COUNT: train_reg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_job(int rc, int tcnt, int tr, int ncols, bit press);
    int n;
    int nt;
    drain();
    write_reg(REG_ROW_COUNT, rc);
    write_reg(REG_TEST_COUNT, tcnt);
    write_reg(REG_TRAIN_COUNT, tr);
    n = eff_rows();
    nt = eff_tests();
    for (int t = 0; t < nt; t++)
      for (int m = 0; m < n; m++)
        send(make_item(KIND_LOAD, m, t));
    if (press) hold_req = 1'b1;
    for (int c = 0; c < ncols; c++) begin
      for (int m = 0; m < n; m++) begin
        if ($urandom_range(0, 99) < 15) begin
          case ($urandom_range(0, 2))
            0: send(make_item(KIND_NONE, $urandom_range(0, 1023), $urandom_range(0, 15)));
            1: send(make_item(KIND_READ, $urandom_range(0, n - 1),
                              $urandom_range(0, nt - 1)));
            default: if (n < MAX_ROWS)
              send(make_item(KIND_ACOL, $urandom_range(n, MAX_ROWS - 1), 0));
          endcase
        end
        send(make_item(KIND_ACOL, m, $urandom_range(0, 15)));
      end
    end
    for (int k = 0; k < 3; k++)
      send(make_item(KIND_READ, $urandom_range(0, n - 1), $urandom_range(0, nt - 1)));
  endtask

  initial begin
    long_hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (3000) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (exp_q.size() == 0) begin
        $display("%t unexpected result: kind %0d test %0d value %h", $realtime,
                 out_if.result_kind, out_if.test_index, out_if.value);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (out_if.result_kind) reads_seen++;
        else dots_seen++;
        if (out_if.result_kind !== e.result_kind ||
            out_if.train_index !== e.train_index ||
            out_if.test_index !== e.test_index || out_if.value !== e.value ||
            out_if.last !== e.last || out_if.final_res !== e.final_res) begin
          $display("%t mismatch: expected kind %0d train %0d test %0d value %h last %0d final %0d",
                   $realtime, e.result_kind, e.train_index, e.test_index, e.value,
                   e.last, e.final_res);
          $display("%t          actual   kind %0d train %0d test %0d value %h last %0d final %0d",
                   $realtime, out_if.result_kind, out_if.train_index,
                   out_if.test_index, out_if.value, out_if.last, out_if.final_res);
          errors++;
        end
      end
    end
    out_if.ready <= long_hold ? 1'b0 :
                    (mode == 0) ? ($urandom_range(0, 99) >= 51) :
                    (mode == 1) ? ($urandom_range(0, 99) >= 25) : 1'b1;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    dir_row_t dir[$];
    dir_row_t d;
    clk = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    sent = 0;
    dots_seen = 0;
    reads_seen = 0;
    mode = 0;
    hold_req = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_NONE;
    in_if.row = '0;
    in_if.col = '0;
    in_if.b_value = '0;
    in_if.residual_value = '0;
    in_if.a_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ROW_COUNT;
    cfg_if.data = '0;
    col_no = '0;
    rows_reg = 11'd1024;
    tests_reg = 5'd16;
    train_reg = 21'd1;

    d.typed = 1'b0;
    d.expv = '0;
    d.it = '{KIND_LOAD, 10'd1023, 4'd15, '1, '1, '0};               dir.push_back(d);
    d.it = '{KIND_LOAD, 10'd0, 4'd0, '0, '0, '1};                   dir.push_back(d);
    d.it = '{KIND_LOAD, 10'd512, 4'd8, 64'h8000_0000_0000_0000,
             64'h8000_0000_0000_0000, '0};                           dir.push_back(d);
    d.it = '{KIND_LOAD, 10'd341, 4'd5, 64'h7FF0_0000_0000_0000,
             64'h7FF8_0000_0000_0001, '0};                           dir.push_back(d);
    d.it = '{KIND_LOAD, 10'd682, 4'd10, 64'h0000_0000_0000_0001,
             64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};      dir.push_back(d);
    d.typed = 1'b1;
    d.it = '{KIND_READ, 10'd1023, 4'd15, '0, '0, '0}; d.expv = '1;  dir.push_back(d);
    d.it = '{KIND_READ, 10'd0, 4'd0, '1, '1, '1};     d.expv = '0;  dir.push_back(d);
    d.it = '{KIND_READ, 10'd512, 4'd8, '0, '0, '0};
    d.expv = 64'h8000_0000_0000_0000;                                dir.push_back(d);
    d.it = '{KIND_READ, 10'd341, 4'd5, '0, '0, '0};
    d.expv = 64'h7FF8_0000_0000_0001;                                dir.push_back(d);
    d.it = '{KIND_READ, 10'd682, 4'd10, '0, '0, '0};
    d.expv = 64'h5555_5555_5555_5555;                                dir.push_back(d);
    d.typed = 1'b0;
    d.it = '{KIND_NONE, 10'd1023, 4'd15, '1, '1, '1};               dir.push_back(d);
    d.it = '{KIND_NONE, 10'd0, 4'd0, '0, '0, '0};                   dir.push_back(d);
    d.it = '{KIND_ACOL, 10'd0, 4'd15, '0, '0, '1};                  dir.push_back(d);
    d.it = '{KIND_ACOL, 10'd1022, 4'd0, '1, '1, '0};                dir.push_back(d);
    d.it = '{KIND_ACOL, 10'd5, 4'd7, '0, '0, 64'h7FF0_0000_0000_0000}; dir.push_back(d);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir[i]) begin
      send(dir[i].it);
      if (dir[i].typed) begin
        void'(exp_q.pop_back());
        exp_q.push_back('{1'b1, '0, dir[i].it.col, dir[i].expv, 1'b0, 1'b0});
      end
    end

    run_job(1, 31, 0, 4, 1'b0);
    run_job(3, 2, 2, 5, 1'b1);
    run_job(4, 1, 2097151, 3, 1'b0);
    for (int j = 0; j < 4; j++)
      run_job($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 4),
              $urandom_range(3, 6), 1'b0);
    run_job(2, 16, 3, 3, 1'b0);
    run_job(5, 0, 0, 2, 1'b0);

    drain();
    $display("Run covered %0d input transfers, %0d dot products and %0d residual reads,",
             sent, dots_seen, reads_seen);
    $display("over row counts 1 to 6, test counts 1 to 16 and several job lengths.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
